// ----- rtl/core/tcce_pkg.sv -----
// tcce_pkg: shared constants, action codes and controller/datapath link types
// for the text console character engine
// no dependencies
package tcce_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // cells moved by one scroll (all rows but the first)
    localparam int COPY_COUNT = CELL_COUNT - COLUMNS;

    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    // stream word widths, data words padded to whole bytes
    localparam int IN_W   = 40;
    localparam int USER_W = 2;
    localparam int OUT_W  = 48;

    // action codes
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_MOVE  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_READ  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic capture;      // take the input word
        logic exec;         // perform the captured action
        logic init_wr;      // reset fill step
        logic clear_wr;     // clear fill step
        logic scroll_step;  // one copy step of the scroll
        logic blank_wr;     // blank one cell of the last row
        logic sweep_clr;    // return the sweep counter to zero
        logic load_out;     // load the result register
        logic scrolled;     // result reports a scroll
    } tcce_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] action;
        logic       put_scroll;  // captured put runs past the last row
        logic       sweep_last;  // sweep at the last cell
        logic       copy_done;   // scroll copy at its final step
        logic       out_free;    // result register can take a word
    } tcce_stat_t;

endpackage

// ----- rtl/core/text_console_character_engine.sv -----
// text_console_character_engine: top level of the character-cell console engine
// depends on tcce_pkg, tcce_ctrl, tcce_datapath
//
// A COLUMNS x ROWS screen of 16-bit cells (attribute high byte, code low byte)
// and a cursor, driven one word at a time. After reset the block fills the
// screen with 0x0F20 in a clearing pass over all CELL_COUNT cells with
// s_tready low; color registers may be written meanwhile. A put or a move is
// then accepted, then executed with the result loaded in the same step; a read
// adds a step (the screen memory has registered read data). A put that runs past the
// last row scrolls: the copy moves one cell a cycle through the single-write
// screen memory, then the last row is blanked. A clear writes every cell. One
// word is in work at a time; a finished result sits in the output register
// while the next word is accepted. Colors are set through the register port:
// fg at 0x0, bg at 0x4.
module text_console_character_engine
    import tcce_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // command stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // char_code, target_col, target_row, cell_index
    input  logic [USER_W-1:0] s_tuser,   // action
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // cursor_col, cursor_row, cursor_position,
                                         // cell_data, scrolled
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    tcce_cmd_t  cmd;
    tcce_stat_t stat;

    // register port never waits
    assign pready = 1'b1;

    // sequencing: init fill, accept, execute, scroll / clear sweeps, result
    tcce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // screen memory, cursor, colors and result register
    tcce_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// ----- rtl/core/tcce_ctrl.sv -----
// tcce_ctrl: sequencing state machine of the console engine
// depends on tcce_pkg
module tcce_ctrl
    import tcce_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  tcce_stat_t stat,
    output tcce_cmd_t  cmd
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_BLANK  = 3'd4;
    localparam logic [2:0] ST_CLEAR  = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_INIT: begin
                cmd.init_wr = 1'b1;
                if (stat.sweep_last) begin
                    cmd.sweep_clr = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (stat.action)
                    ACT_PUT: begin
                        if (stat.put_scroll) begin
                            cmd.exec   = 1'b1;
                            state_next = ST_SCROLL;
                        end else if (stat.out_free) begin
                            cmd.exec     = 1'b1;
                            cmd.load_out = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    ACT_MOVE: begin
                        if (stat.out_free) begin
                            cmd.exec     = 1'b1;
                            cmd.load_out = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    ACT_CLEAR: begin
                        cmd.exec   = 1'b1;
                        state_next = ST_CLEAR;
                    end
                    ACT_READ: begin
                        cmd.exec   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCROLL: begin
                cmd.scroll_step = 1'b1;
                if (stat.copy_done) begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK: begin
                cmd.blank_wr = 1'b1;
                if (stat.sweep_last) begin
                    cmd.sweep_clr = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (stat.sweep_last) begin
                    cmd.sweep_clr = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.scrolled = (stat.action == ACT_PUT);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

// ----- rtl/core/tcce_datapath.sv -----
// tcce_datapath: screen memory, cursor, sweep counter, color registers
// and result register of the console engine
// depends on tcce_pkg
module tcce_datapath
    import tcce_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input word
    input  logic [IN_W-1:0]   s_tdata,
    input  logic [USER_W-1:0] s_tuser,
    // result word
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,
    // color registers
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    // controller link
    input  tcce_cmd_t         cmd,
    output tcce_stat_t        stat
);

    localparam logic [7:0]  CODE_NEWLINE   = 8'd10;
    localparam logic [7:0]  CODE_RETURN    = 8'd13;
    localparam logic [7:0]  CODE_BACKSPACE = 8'd8;
    localparam logic [7:0]  CODE_SPACE     = 8'd32;
    localparam logic [15:0] RESET_CELL     = 16'h0F20;
    localparam logic        REG_FG         = 1'b0;
    localparam logic        REG_BG         = 1'b1;

    // captured item
    logic [1:0]  action_reg;
    logic [7:0]  code_reg;
    logic [7:0]  tcol_reg;
    logic [5:0]  trow_reg;
    logic [10:0] idx_reg;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] sweep_reg;
    logic [3:0]        fg_reg, bg_reg;

    logic [15:0]       mem [CELL_COUNT];
    logic [15:0]       rd_data_reg;

    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    logic [7:0]        attr;
    logic [15:0]       blank;
    logic              col_last, row_last, printable, idx_ok;
    logic              inc_row, we_exec;
    logic [COL_W-1:0]  wcol;
    logic [15:0]       wcell;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [15:0]       mem_wdata;

    logic [13:0]       pos_next;
    logic [15:0]       cell_out;

    assign attr      = {bg_reg, fg_reg};
    assign blank     = {attr, CODE_SPACE};
    assign col_last  = (col_reg == COL_W'(COLUMNS - 1));
    assign row_last  = (row_reg == ROW_W'(ROWS - 1));
    assign printable = (code_reg != CODE_NEWLINE) && (code_reg != CODE_RETURN)
                       && (code_reg != CODE_BACKSPACE);
    assign idx_ok    = (32'(idx_reg) < 32'(CELL_COUNT));

    // status
    assign stat.action     = action_reg;
    assign stat.put_scroll = (action_reg == ACT_PUT) && row_last
                             && ((code_reg == CODE_NEWLINE) || (printable && col_last));
    assign stat.sweep_last = (sweep_reg == ADDR_W'(CELL_COUNT - 1));
    assign stat.copy_done  = (sweep_reg == ADDR_W'(COPY_COUNT));
    assign stat.out_free   = !m_tvalid_reg || m_tready;

    // color registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= 4'd15;
            bg_reg <= 4'd0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_FG) begin
                fg_reg <= pwdata[3:0];
            end else begin
                bg_reg <= pwdata[3:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_BG) ? {28'd0, bg_reg} : {28'd0, fg_reg};

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= s_tuser[1:0];
            code_reg   <= s_tdata[7:0];
            tcol_reg   <= s_tdata[15:8];
            trow_reg   <= s_tdata[21:16];
            idx_reg    <= s_tdata[32:22];
        end
    end

    // cursor update and cell write of one action
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        inc_row  = 1'b0;
        we_exec  = 1'b0;
        wcol     = col_reg;
        wcell    = {attr, code_reg};
        if (cmd.exec) begin
            case (action_reg)
                ACT_PUT: begin
                    if (code_reg == CODE_NEWLINE) begin
                        col_next = '0;
                        inc_row  = 1'b1;
                    end else if (code_reg == CODE_RETURN) begin
                        col_next = '0;
                    end else if (code_reg == CODE_BACKSPACE) begin
                        if (col_reg != '0) begin
                            col_next = col_reg - 1'b1;
                            wcol     = col_reg - 1'b1;
                            wcell    = blank;
                            we_exec  = 1'b1;
                        end
                    end else begin
                        we_exec = 1'b1;
                        if (col_last) begin
                            col_next = '0;
                            inc_row  = 1'b1;
                        end else begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                    // past the last row the scroll keeps the cursor there
                    if (inc_row && !row_last) begin
                        row_next = row_reg + 1'b1;
                    end
                end
                ACT_MOVE: begin
                    col_next = ({1'b0, tcol_reg} >= 9'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                                 : COL_W'(tcol_reg);
                    row_next = ({1'b0, trow_reg} >= 7'(ROWS)) ? ROW_W'(ROWS - 1)
                                                              : ROW_W'(trow_reg);
                end
                ACT_CLEAR: begin
                    col_next = '0;
                    row_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // sweep counter for fill, clear and scroll
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_reg <= '0;
        end else if (cmd.sweep_clr) begin
            sweep_reg <= '0;
        end else if (cmd.init_wr || cmd.clear_wr || cmd.blank_wr
                     || (cmd.scroll_step && !stat.copy_done)) begin
            sweep_reg <= sweep_reg + 1'b1;
        end
    end

    // memory port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = RESET_CELL;
        mem_re    = 1'b0;
        mem_raddr = ADDR_W'(idx_reg);
        if (cmd.init_wr) begin
            mem_we = 1'b1;
        end else if (cmd.clear_wr || cmd.blank_wr) begin
            mem_we    = 1'b1;
            mem_wdata = blank;
        end else if (cmd.scroll_step) begin
            // read one row ahead, write the previous read one step behind
            mem_re    = !stat.copy_done;
            mem_raddr = ADDR_W'(32'(sweep_reg) + 32'(COLUMNS));
            mem_we    = (sweep_reg != '0);
            mem_waddr = sweep_reg - 1'b1;
            mem_wdata = rd_data_reg;
        end else if (cmd.exec) begin
            if (action_reg == ACT_PUT) begin
                mem_we    = we_exec;
                mem_waddr = ADDR_W'(32'(row_reg) * 32'(COLUMNS) + 32'(wcol));
                mem_wdata = wcell;
            end else if (action_reg == ACT_READ) begin
                mem_re = idx_ok;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // result register
    assign pos_next = 14'(32'(row_next) * 32'(COLUMNS) + 32'(col_next));
    assign cell_out = ((action_reg == ACT_READ) && idx_ok) ? rd_data_reg : 16'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {3'd0, cmd.scrolled, cell_out, pos_next,
                            6'(row_next), 8'(col_next)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/core/tcce_checker.sv -----
// tcce_checker: port-level checks of the console engine, bound to the top level
// depends on tcce_pkg, text_console_character_engine
module tcce_checker
    import tcce_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one word in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is in work");

    // cursor stays on the screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[7:0]) < COLUMNS) && (32'(m_tdata[13:8]) < ROWS))
        else $error("cursor off screen");

    // linear position agrees with row and column
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[27:14]
                     == 14'(32'(m_tdata[13:8]) * COLUMNS + 32'(m_tdata[7:0])))
        else $error("cursor position mismatch");

    // a scroll leaves the cursor at the start of the last row
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[44] |-> (32'(m_tdata[13:8]) == ROWS - 1)
                                    && (m_tdata[7:0] == 8'd0))
        else $error("scroll left cursor elsewhere");

endmodule

bind text_console_character_engine tcce_checker u_tcce_checker (.*);

// ----- tb/tb_console_pkg.sv -----
// tb_console_pkg: word layouts, control codes and register addresses shared by
// the console testbench top and its checker
// no dependencies
package tb_console_pkg;

    // control codes that a put word can carry
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // color register addresses
    localparam logic [2:0] ADDR_FG = 3'd0;
    localparam logic [2:0] ADDR_BG = 3'd4;

    // command word on s_tdata, lowest field last
    typedef struct packed {
        logic [6:0]  pad;
        logic [10:0] cell_index;
        logic [5:0]  target_row;
        logic [7:0]  target_col;
        logic [7:0]  char_code;
    } cmd_word_t;

    // result word on m_tdata, lowest field last
    typedef struct packed {
        logic [2:0]  pad;
        logic        scrolled;
        logic [15:0] cell_data;
        logic [13:0] cursor_position;
        logic [5:0]  cursor_row;
        logic [7:0]  cursor_col;
    } cursor_word_t;

endpackage

// ----- tb/tb_console_checker.sv -----
// tb_console_checker: mirrors the console screen and cursor, predicts each
// result word and compares it with what the block sends
// depends on tcce_pkg and tb_console_pkg
module tb_console_checker
    import tcce_pkg::*;
    import tb_console_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic [USER_W-1:0] s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                failures,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] POWER_UP_CELL = 16'h0F20;

    logic [15:0]  screen [CELL_COUNT];
    int unsigned  cur_col;
    int unsigned  cur_row;
    logic [3:0]   fg_color;
    logic [3:0]   bg_color;
    cursor_word_t cursor_q [$];
    int           fail_n = 0;

    function automatic logic [15:0] attr_cell(logic [7:0] code);
        return {bg_color, fg_color, code};
    endfunction

    // applies one command to the mirrored screen and returns its result word
    function automatic cursor_word_t console_step(logic [1:0] act, cmd_word_t w);
        cursor_word_t r;
        int unsigned  tcol;
        int unsigned  trow;
        r = '0;
        case (act)
            ACT_PUT: begin
                if (w.char_code == CH_NEWLINE) begin
                    cur_col = 0;
                    cur_row++;
                end else if (w.char_code == CH_RETURN) begin
                    cur_col = 0;
                end else if (w.char_code == CH_BACKSPACE) begin
                    if (cur_col > 0) begin
                        cur_col--;
                        screen[cur_row * COLUMNS + cur_col] = attr_cell(CH_SPACE);
                    end
                end else begin
                    screen[cur_row * COLUMNS + cur_col] = attr_cell(w.char_code);
                    cur_col++;
                    if (cur_col >= COLUMNS) begin
                        cur_col = 0;
                        cur_row++;
                    end
                end
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < COPY_COUNT; i++)
                        screen[i] = screen[i + COLUMNS];
                    for (int i = COPY_COUNT; i < CELL_COUNT; i++)
                        screen[i] = attr_cell(CH_SPACE);
                    cur_row = ROWS - 1;
                    r.scrolled = 1'b1;
                end
            end
            ACT_MOVE: begin
                tcol = 32'(w.target_col);
                trow = 32'(w.target_row);
                cur_col = (tcol >= COLUMNS) ? COLUMNS - 1 : tcol;
                cur_row = (trow >= ROWS) ? ROWS - 1 : trow;
            end
            ACT_CLEAR: begin
                cur_col = 0;
                cur_row = 0;
                for (int i = 0; i < CELL_COUNT; i++)
                    screen[i] = attr_cell(CH_SPACE);
            end
            ACT_READ: begin
                if (w.cell_index < CELL_COUNT)
                    r.cell_data = screen[w.cell_index];
            end
            default: begin
            end
        endcase
        r.cursor_col      = 8'(cur_col);
        r.cursor_row      = 6'(cur_row);
        r.cursor_position = 14'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_n++;
        end
    endtask

    always @(posedge aclk) begin
        cursor_word_t got;
        cursor_word_t want;
        if (!aresetn) begin
            for (int i = 0; i < CELL_COUNT; i++)
                screen[i] = POWER_UP_CELL;
            cur_col  = 0;
            cur_row  = 0;
            fg_color = 4'd15;
            bg_color = 4'd0;
            cursor_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_FG)
                    fg_color = pwdata[3:0];
                else if (paddr == ADDR_BG)
                    bg_color = pwdata[3:0];
            end
            // a result never belongs to the command taken at the same edge
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (cursor_q.size() == 0) begin
                    $error("result word with no command waiting");
                    fail_n++;
                end else begin
                    want = cursor_q.pop_front();
                    check_field("cursor_col", 32'(want.cursor_col), 32'(got.cursor_col));
                    check_field("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row));
                    check_field("cursor_position", 32'(want.cursor_position),
                                32'(got.cursor_position));
                    check_field("cell_data", 32'(want.cell_data), 32'(got.cell_data));
                    check_field("scrolled", 32'(want.scrolled), 32'(got.scrolled));
                end
            end
            if (s_tvalid && s_tready)
                cursor_q.push_back(console_step(s_tuser, s_tdata));
        end
        failures <= fail_n;
        pending  <= cursor_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// tb_top: stimulus and verdict for the text console character engine
// depends on tcce_pkg, tb_console_pkg, tb_console_checker and the block itself
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tcce_pkg::*;
    import tb_console_pkg::*;

    // cycles with no word taken on either side before the run is called hung;
    // the slowest gap is the fill after reset or a scroll or clear sweep of about
    // the same length, plus both sides' longest stalls
    localparam int IDLE_LIMIT   = 20000;
    localparam int PHASE_WORDS  = 170;
    localparam int PHASE_COUNT  = 5;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic [USER_W-1:0] s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [2:0]        paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    int failures;
    int pending;
    int idle_cycles = 0;
    bit no_idle     = 1'b0;  // set for stretches where neither side stalls

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    text_console_character_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tb_console_checker checker_i (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .failures (failures),
        .pending  (pending)
    );

    // stall length drawn afresh for every word on either side
    function automatic int pick_gap();
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic cmd_word_t cmd(logic [7:0] code, logic [7:0] col,
                                      logic [5:0] row, logic [10:0] idx);
        cmd_word_t w;
        w            = '0;
        w.char_code  = code;
        w.target_col = col;
        w.target_row = row;
        w.cell_index = idx;
        return w;
    endfunction

    // offers one command word; called and returning at a rising edge.
    // tvalid is only dropped when a gap follows, so it never falls and
    // rises within one step
    task automatic send_word(logic [1:0] act, cmd_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stops offering words and waits until every result has come back;
    // the extra edge lets the checker count the last word taken
    task automatic drain_words();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // setup, then access, then idle before returning; pready is always high
    task automatic reg_write(logic [2:0] addr, logic [3:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {28'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // colors only change while no word is in flight
    task automatic set_colors(logic [3:0] fg, logic [3:0] bg);
        drain_words();
        reg_write(ADDR_FG, fg);
        reg_write(ADDR_BG, bg);
    endtask

    // mostly puts, a share of moves biased toward the bottom rows so that
    // scrolls happen, plenty of reads and a rare clear
    task automatic random_word();
        cmd_word_t   w;
        int unsigned pick;
        logic [1:0]  act;
        w            = '0;
        w.char_code  = 8'($urandom);
        w.target_col = 8'($urandom);
        w.target_row = 6'($urandom);
        w.cell_index = 11'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            act  = ACT_PUT;
            pick = $urandom_range(0, 19);
            if (pick < 2)
                w.char_code = CH_NEWLINE;
            else if (pick < 3)
                w.char_code = CH_RETURN;
            else if (pick < 5)
                w.char_code = CH_BACKSPACE;
        end else if (pick < 70) begin
            act = ACT_MOVE;
            if ($urandom_range(0, 1))
                w.target_row = 6'($urandom_range(ROWS - 2, 63));
        end else if (pick < 98) begin
            act = ACT_READ;
        end else begin
            act = ACT_CLEAR;
        end
        send_word(act, w);
    endtask

    // result side: a fresh stall after every word taken, tready held otherwise
    initial begin
        int stall;
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // watchdog on words taken at either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // power-up screen, both ends and past the end of the store
        send_word(ACT_READ, cmd(8'd0, 8'd0, 6'd0, 11'd0));
        send_word(ACT_READ, cmd(8'd0, 8'd0, 6'd0, 11'(CELL_COUNT - 1)));
        send_word(ACT_READ, cmd(8'd0, 8'd0, 6'd0, 11'(CELL_COUNT)));
        send_word(ACT_READ, cmd(8'd0, 8'd0, 6'd0, 11'h7FF));
        // backspace at column zero does nothing
        send_word(ACT_PUT, cmd(CH_BACKSPACE, 8'd0, 6'd0, 11'd0));
        // printable extremes, then a backspace that blanks the last one
        send_word(ACT_PUT, cmd(8'h41, 8'd0, 6'd0, 11'd0));
        send_word(ACT_PUT, cmd(8'hFF, 8'd0, 6'd0, 11'd0));
        send_word(ACT_PUT, cmd(8'h00, 8'd0, 6'd0, 11'd0));
        send_word(ACT_PUT, cmd(CH_BACKSPACE, 8'd0, 6'd0, 11'd0));
        send_word(ACT_READ, cmd(8'd0, 8'd0, 6'd0, 11'd2));
        send_word(ACT_PUT, cmd(CH_RETURN, 8'd0, 6'd0, 11'd0));
        send_word(ACT_PUT, cmd(CH_NEWLINE, 8'd0, 6'd0, 11'd0));

        // opposite color extremes for the rest of the directed words
        set_colors(4'd0, 4'd15);
        // move far out of range clamps to the bottom-right cell
        send_word(ACT_MOVE, cmd(8'd0, 8'hFF, 6'h3F, 11'd0));
        // a put there wraps past the last row and scrolls
        send_word(ACT_PUT, cmd(8'h5A, 8'd0, 6'd0, 11'd0));
        send_word(ACT_READ, cmd(8'd0, 8'd0, 6'd0, 11'(COPY_COUNT - 1)));
        send_word(ACT_READ, cmd(8'd0, 8'd0, 6'd0, 11'(COPY_COUNT)));
        send_word(ACT_MOVE, cmd(8'd0, 8'(COLUMNS - 1), 6'(ROWS - 1), 11'd0));
        // newline on the last row scrolls too
        send_word(ACT_PUT, cmd(CH_NEWLINE, 8'd0, 6'd0, 11'd0));
        send_word(ACT_MOVE, cmd(8'd0, 8'd0, 6'd0, 11'd0));
        // clear blanks with the current colors and homes the cursor
        send_word(ACT_CLEAR, cmd(8'd0, 8'd3, 6'd3, 11'd5));
        send_word(ACT_READ, cmd(8'd0, 8'd0, 6'd0, 11'd0));
        // just past the screen on both coordinates
        send_word(ACT_MOVE, cmd(8'd0, 8'(COLUMNS), 6'(ROWS), 11'd0));
        send_word(ACT_PUT, cmd(8'h78, 8'd0, 6'd0, 11'd0));
        send_word(ACT_READ, cmd(8'd0, 8'd0, 6'd0, 11'(CELL_COUNT - 1)));

        // random phases, each under its own colors; one phase runs without
        // stalls on either side
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0:       set_colors(4'd15, 4'd15);
                1:       set_colors(4'd0, 4'd0);
                default: set_colors(4'($urandom), 4'($urandom));
            endcase
            no_idle = (p == 2);
            for (int n = 0; n < PHASE_WORDS; n++)
                random_word();
        end

        drain_words();
        repeat (20) @(posedge aclk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
